### hw/rtl/oewma_pkg.sv
// ----------------------------------------------------------------------------
// oewma_pkg
// Shared widths, constants and register indexes of the oversampled moving
// average block.
// ----------------------------------------------------------------------------
package oewma_pkg;

  localparam int ChanW    = 2;
  localparam int SampleW  = 10;
  localparam int ValW     = 13;
  localparam int AvgW     = 24;
  localparam int ShiftW   = 4;
  localparam int RefW     = 13;
  localparam int MaskW    = 3;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 13;
  localparam int SDataW   = 16;
  localparam int MDataW   = 32;

  localparam logic [ShiftW-1:0] ShiftMax = 4'd8;
  localparam logic [ValW-1:0]   OutMax   = 13'd8191;

  localparam logic [ShiftW-1:0] ShiftReset = 4'd4;
  localparam logic [RefW-1:0]   RefReset   = 13'd1100;
  localparam logic [MaskW-1:0]  MaskReset  = 3'd3;

  typedef enum logic [CfgAddrW-1:0] {
    RegEwmaShift   = 2'd0,
    RegReferenceMv = 2'd1,
    RegRatioMask   = 2'd2
  } cfg_reg_t;

endpackage

### hw/rtl/oversampled_ewma_averager.sv
// ----------------------------------------------------------------------------
// oversampled_ewma_averager
// Burst oversampling of converter samples with a per-channel moving average.
// ----------------------------------------------------------------------------
// The block takes one sample word in every cycle. Burst bookkeeping happens
// as a word is accepted; a word that closes a burst moves into a compute
// register, and the scaling multiply and the moving average update run
// between that register and the output register, which holds the result
// word of the burst. The input is only held off when the output register
// is stalled and a finished burst is already waiting in the compute
// register.
module oversampled_ewma_averager #(
  parameter int BURST_LENGTH = 17,
  parameter int CHANNELS     = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [oewma_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [oewma_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0: channel[1:0], sample[11:2], zero padding.
  input  logic [oewma_pkg::SDataW-1:0]    s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Fields from bit 0: result_channel[1:0], burst_value[14:2],
  // filtered_value[27:15], zero padding.
  output logic [oewma_pkg::MDataW-1:0]    m_tdata
);

  localparam int CntW = $clog2(BURST_LENGTH + 1);
  localparam int SumW = $clog2((BURST_LENGTH - 1) * 1023 + 1);
  localparam int QW   = (SumW > 15) ? SumW - 2 : 13;
  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CntW-1:0] BurstLen = CntW'(BURST_LENGTH);

  logic [oewma_pkg::ShiftW-1:0] ewma_shift;
  logic [oewma_pkg::RefW-1:0]   reference_mv;
  logic [oewma_pkg::MaskW-1:0]  ratio_mask;

  logic [CntW-1:0]              burst_count;
  logic [SumW-1:0]              burst_sum;
  logic [oewma_pkg::ChanW-1:0]  burst_channel;

  logic                         calc_valid;
  logic [oewma_pkg::ChanW-1:0]  calc_channel;
  logic [SumW-1:0]              calc_sum;

  logic [oewma_pkg::AvgW-1:0]   channel_average [CHANNELS];
  logic [CHANNELS-1:0]          average_valid;

  logic [oewma_pkg::ChanW-1:0]  out_channel;
  logic [oewma_pkg::ValW-1:0]   out_burst;
  logic [oewma_pkg::ValW-1:0]   out_filtered;

  logic [oewma_pkg::ChanW-1:0]  in_channel;
  logic [oewma_pkg::SampleW-1:0] in_sample;
  logic                         in_accept;
  logic                         in_ok;
  logic                         same_burst;
  logic [CntW-1:0]              count_base;
  logic [SumW-1:0]              sum_base;
  logic [SumW-1:0]              sum_next;
  logic [CntW-1:0]              count_next;
  logic                         burst_done;
  logic                         calc_adv;

  logic [IdxW-1:0]              calc_idx;
  logic [QW-1:0]                quarter;
  logic [oewma_pkg::ValW-1:0]   val_raw;
  logic [2*oewma_pkg::ValW-1:0] product;
  logic [oewma_pkg::ValW:0]     scaled;
  logic [oewma_pkg::ValW-1:0]   val_abs;
  logic [oewma_pkg::ValW-1:0]   value;
  logic [3:0]                   mask_ext;
  logic [oewma_pkg::ShiftW-1:0] shift;
  logic [oewma_pkg::AvgW-1:0]   avg_old;
  logic [oewma_pkg::AvgW-1:0]   avg_next;
  logic [oewma_pkg::AvgW-1:0]   filt_full;
  logic [oewma_pkg::ValW-1:0]   filtered;

  assign in_channel = s_tdata[1:0];
  assign in_sample  = s_tdata[11:2];

  assign calc_adv  = calc_valid && (!m_tvalid || m_tready);
  assign s_tready  = !calc_valid || calc_adv;
  assign in_accept = s_tvalid && s_tready;
  assign in_ok     = int'(in_channel) < CHANNELS;

  always_comb begin
    same_burst = in_channel == burst_channel;
    count_base = same_burst ? burst_count : '0;
    sum_base   = same_burst ? burst_sum : '0;
    sum_next   = (count_base != '0) ? SumW'(sum_base + SumW'(in_sample)) : sum_base;
    count_next = CntW'(count_base + 1'b1);
    burst_done = count_next == BurstLen;
  end

  always_comb begin
    calc_idx = IdxW'(calc_channel);
    quarter  = QW'(calc_sum >> 2);
    val_raw  = (quarter > QW'(oewma_pkg::OutMax)) ? oewma_pkg::OutMax
                                                  : quarter[oewma_pkg::ValW-1:0];
    product  = val_raw * reference_mv;
    scaled   = product[2*oewma_pkg::ValW-1:12];
    val_abs  = (scaled > {1'b0, oewma_pkg::OutMax}) ? oewma_pkg::OutMax
                                                    : scaled[oewma_pkg::ValW-1:0];
    mask_ext = {1'b0, ratio_mask};
    value    = mask_ext[calc_channel] ? val_raw : val_abs;
    shift    = (ewma_shift > oewma_pkg::ShiftMax) ? oewma_pkg::ShiftMax : ewma_shift;
    avg_old  = channel_average[calc_idx];
    if (!average_valid[calc_idx]) begin
      avg_next = oewma_pkg::AvgW'(value) << shift;
    end else begin
      avg_next = avg_old + oewma_pkg::AvgW'(value) - (avg_old >> shift);
    end
    filt_full = avg_next >> shift;
    filtered  = (filt_full > oewma_pkg::AvgW'(oewma_pkg::OutMax)) ? oewma_pkg::OutMax
                                                                  : filt_full[12:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ewma_shift   <= oewma_pkg::ShiftReset;
      reference_mv <= oewma_pkg::RefReset;
      ratio_mask   <= oewma_pkg::MaskReset;
    end else if (cfg_wen) begin
      unique case (oewma_pkg::cfg_reg_t'(cfg_addr))
        oewma_pkg::RegEwmaShift:   ewma_shift   <= cfg_wdata[oewma_pkg::ShiftW-1:0];
        oewma_pkg::RegReferenceMv: reference_mv <= cfg_wdata[oewma_pkg::RefW-1:0];
        oewma_pkg::RegRatioMask:   ratio_mask   <= cfg_wdata[oewma_pkg::MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_count   <= '0;
      burst_sum     <= '0;
      burst_channel <= '0;
      calc_valid    <= 1'b0;
    end else begin
      if (calc_adv && !(in_accept && in_ok && burst_done)) begin
        calc_valid <= 1'b0;
      end
      if (in_accept && in_ok) begin
        burst_channel <= in_channel;
        if (burst_done) begin
          burst_count <= '0;
          burst_sum   <= '0;
          calc_valid  <= 1'b1;
        end else begin
          burst_count <= count_next;
          burst_sum   <= sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_ok && burst_done) begin
      calc_channel <= in_channel;
      calc_sum     <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average_valid <= '0;
      m_tvalid      <= 1'b0;
    end else if (calc_adv) begin
      average_valid[calc_idx] <= 1'b1;
      m_tvalid                <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_adv) begin
      channel_average[calc_idx] <= avg_next;
      out_channel               <= calc_channel;
      out_burst                 <= value;
      out_filtered              <= filtered;
    end
  end

  assign m_tdata = {4'b0000, out_filtered, out_burst, out_channel};

endmodule

### hw/rtl/oewma_checker.sv
// ----------------------------------------------------------------------------
// oewma_checker
// Port-level checks of the oversampled moving average block.
// ----------------------------------------------------------------------------
module oewma_checker #(
  parameter int CHANNELS = 3
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [oewma_pkg::MDataW-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result word changed.");

  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> int'(m_tdata[1:0]) < CHANNELS)
    else $error("Result carries a channel that is not configured.");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:28] == 4'b0000)
    else $error("Result padding bits are not zero.");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("Input held off while the output register is empty.");

endmodule

bind oversampled_ewma_averager oewma_checker #(.CHANNELS(CHANNELS)) u_oewma_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the oversampled moving average block. Sample words
// are driven in bursts with random content, gaps and channel noise, result
// words are compared field by field against a predicting scoreboard, and the
// registers are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Channels    = 3;
  localparam int BurstLen    = 17;
  localparam logic [oewma_pkg::ChanW-1:0] IgnoredChan = 2'd3;
  localparam int SettleCycles = 8;
  localparam int HoldCycles  = 400;
  localparam int WatchLimit  = 3000;
  localparam int PhaseItems  = 165;
  localparam int NumPhases   = 8;

  typedef struct packed {
    logic [oewma_pkg::ChanW-1:0] chan;
    logic [oewma_pkg::ValW-1:0]  burst;
    logic [oewma_pkg::ValW-1:0]  filt;
  } avg_result_t;

  class ewma_scoreboard;
    logic [oewma_pkg::ShiftW-1:0] shift_reg;
    logic [oewma_pkg::RefW-1:0]   ref_mv;
    logic [oewma_pkg::MaskW-1:0]  ratio_mask;
    logic [oewma_pkg::AvgW-1:0]   avg_mem[Channels];
    bit                           avg_loaded[Channels];
    logic [4:0]                   burst_cnt;
    logic [13:0]                  burst_acc;
    logic [oewma_pkg::ChanW-1:0]  burst_chan;
    avg_result_t                  pending[$];
    int                           errors;

    function new();
      shift_reg  = oewma_pkg::ShiftReset;
      ref_mv     = oewma_pkg::RefReset;
      ratio_mask = oewma_pkg::MaskReset;
      foreach (avg_mem[i]) begin
        avg_mem[i]    = '0;
        avg_loaded[i] = 1'b0;
      end
      burst_cnt  = '0;
      burst_acc  = '0;
      burst_chan = '0;
      errors     = 0;
    endfunction

    function logic [oewma_pkg::ValW-1:0] clip(int unsigned v);
      return (v > 32'(oewma_pkg::OutMax)) ? oewma_pkg::OutMax : v[oewma_pkg::ValW-1:0];
    endfunction

    function void set_reg(oewma_pkg::cfg_reg_t idx, logic [oewma_pkg::CfgDataW-1:0] d);
      case (idx)
        oewma_pkg::RegEwmaShift:   shift_reg  = d[oewma_pkg::ShiftW-1:0];
        oewma_pkg::RegReferenceMv: ref_mv     = d[oewma_pkg::RefW-1:0];
        oewma_pkg::RegRatioMask:   ratio_mask = d[oewma_pkg::MaskW-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [oewma_pkg::ChanW-1:0] ch,
                              logic [oewma_pkg::SampleW-1:0] smp);
      int unsigned eff_shift;
      int unsigned v;
      int unsigned a;
      avg_result_t r;
      if (ch >= Channels) return;
      if (ch != burst_chan) begin
        burst_chan = ch;
        burst_cnt  = '0;
        burst_acc  = '0;
      end
      if (burst_cnt > 0) burst_acc = burst_acc + 14'(smp);
      burst_cnt = burst_cnt + 5'd1;
      if (burst_cnt < BurstLen) return;
      eff_shift = (shift_reg > oewma_pkg::ShiftMax) ? 32'(oewma_pkg::ShiftMax)
                                                    : 32'(shift_reg);
      v = 32'(clip(32'(burst_acc >> 2)));
      if (!ratio_mask[ch]) v = 32'(clip((v * 32'(ref_mv)) >> 12));
      if (!avg_loaded[ch]) begin
        a = (v << eff_shift) & 32'hFF_FFFF;
        avg_loaded[ch] = 1'b1;
      end else begin
        a = 32'(avg_mem[ch]);
        a = (a + v - (a >> eff_shift)) & 32'hFF_FFFF;
      end
      avg_mem[ch] = a[oewma_pkg::AvgW-1:0];
      burst_cnt = '0;
      burst_acc = '0;
      r.chan  = ch;
      r.burst = v[oewma_pkg::ValW-1:0];
      r.filt  = clip(a >> eff_shift);
      pending.push_back(r);
    endfunction

    function void check_word(logic [oewma_pkg::MDataW-1:0] w);
      avg_result_t e;
      if (pending.size() == 0) begin
        $error("result word 0x%08h arrived with nothing expected", w);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (w[1:0] !== e.chan) begin
        $error("result_channel: expected %0d, actual %0d", e.chan, w[1:0]);
        errors++;
      end
      if (w[14:2] !== e.burst) begin
        $error("burst_value: expected %0d, actual %0d", e.burst, w[14:2]);
        errors++;
      end
      if (w[27:15] !== e.filt) begin
        $error("filtered_value: expected %0d, actual %0d", e.filt, w[27:15]);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          cfg_wen;
  logic [oewma_pkg::CfgAddrW-1:0] cfg_addr;
  logic [oewma_pkg::CfgDataW-1:0] cfg_wdata;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [oewma_pkg::SDataW-1:0]  s_tdata;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [oewma_pkg::MDataW-1:0]  m_tdata;

  ewma_scoreboard sb = new();
  bit calm;
  bit hold_req;
  int hold_left;
  int quiet_cycles;

  oversampled_ewma_averager dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_sample(s_tdata[1:0], s_tdata[11:2]);
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_sample(input logic [oewma_pkg::ChanW-1:0] ch,
                             input logic [oewma_pkg::SampleW-1:0] smp);
    while (!calm && $urandom_range(99) < 32) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(oewma_pkg::SDataW - oewma_pkg::SampleW - oewma_pkg::ChanW){1'b0}},
                 smp, ch};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input oewma_pkg::cfg_reg_t idx,
                           input logic [oewma_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic run_random(input int n);
    int sent;
    int pick;
    int mode;
    int len;
    logic [oewma_pkg::ChanW-1:0] ch;
    logic [oewma_pkg::SampleW-1:0] smp;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      ch   = oewma_pkg::ChanW'($urandom_range(Channels - 1));
      if (pick < 80) begin
        mode = $urandom_range(3);
        for (int k = 0; k < BurstLen; k++) begin
          case (mode)
            0: smp = oewma_pkg::SampleW'($urandom_range(1023));
            1: smp = '1;
            2: smp = '0;
            default: smp = oewma_pkg::SampleW'($urandom_range(600, 400));
          endcase
          send_sample(ch, smp);
          sent++;
          if ($urandom_range(99) < 3) begin
            send_sample(IgnoredChan, oewma_pkg::SampleW'($urandom_range(1023)));
          end
        end
      end else if (pick < 95) begin
        len = int'($urandom_range(BurstLen - 1, 1));
        for (int k = 0; k < len; k++) begin
          send_sample(ch, oewma_pkg::SampleW'($urandom_range(1023)));
          sent++;
        end
      end else begin
        send_sample(IgnoredChan, oewma_pkg::SampleW'($urandom_range(1023)));
      end
    end
  endtask

  int shift_tab[NumPhases] = '{0, 8, 15, 2, 9, 0, 0, 0};
  int ref_tab[NumPhases]   = '{1, 5000, 8191, 0, 4095, 0, 0, 0};
  int mask_tab[NumPhases]  = '{0, 7, 0, 5, 2, 0, 0, 0};

  initial begin
    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    hold_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Ignored channel, a partial burst that a channel change cuts off, then a
    // full-scale burst with an ignored word in its middle.
    send_sample(IgnoredChan, '1);
    repeat (3) send_sample(2'd1, '0);
    send_sample(2'd0, '0);
    for (int k = 0; k < BurstLen - 1; k++) begin
      send_sample(2'd0, '1);
      if (k == 7) send_sample(IgnoredChan, '0);
    end
    run_random(PhaseItems);
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      if (p >= 5) begin
        shift_tab[p] = $urandom_range(15);
        ref_tab[p]   = $urandom_range(8191);
        mask_tab[p]  = $urandom_range(7);
      end
      write_reg(oewma_pkg::RegEwmaShift, oewma_pkg::CfgDataW'(shift_tab[p]));
      write_reg(oewma_pkg::RegReferenceMv, oewma_pkg::CfgDataW'(ref_tab[p]));
      write_reg(oewma_pkg::RegRatioMask, oewma_pkg::CfgDataW'(mask_tab[p]));
      @(negedge clk);
      cfg_wen <= 1'b0;
      calm = (p == 0) || (p == 2);
      if (p == 2) hold_req = 1'b1;
      run_random(PhaseItems);
      calm = 1'b0;
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
